### rtl/bbc_pkg.sv
package bbc_pkg;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_STRAY   = 3'd1,
		ERR_ROUND   = 3'd2,
		ERR_CURLY   = 3'd3,
		ERR_SQUARE  = 3'd4,
		ERR_NO_TERM = 3'd5
	} err_code_t;

	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LCURLY  = 8'h7B;
	localparam logic [7:0] CH_RCURLY  = 8'h7D;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_GREATER = 8'h3E;
	localparam logic [7:0] CH_SEMI    = 8'h3B;

	typedef struct packed {
		logic        ok;
		err_code_t   code;
		logic [15:0] line;
		logic [15:0] column;
	} result_t;

endpackage

### rtl/bbc_scan.sv
module bbc_scan
	import bbc_pkg::*;
#(
	parameter int COUNTER_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] character,
	input  logic       last,
	input  logic       empty_source,
	output logic       produce,
	output result_t    result
);

	localparam int W = COUNTER_BITS;
	localparam logic [W-1:0] ONE = W'(1);

	logic [W-1:0] line_q, col_q, rnd_q, cur_q, sqr_q;
	logic         peq_q, arrow_q, semi_q, drain_q;
	logic [W-1:0] line_d, col_d, rnd_d, cur_d, sqr_d;
	logic         peq_d, arrow_d, semi_d, drain_d;
	logic         stray, fin, clear;

	function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
		return (&v) ? v : v + ONE;
	endfunction

	function automatic logic [15:0] pos16(input logic [W-1:0] v);
		logic [31:0] e;
		e = 32'(v);
		return (e > 32'h0000_FFFF) ? 16'hFFFF : e[15:0];
	endfunction

	always_comb begin
		line_d  = line_q;
		col_d   = col_q;
		rnd_d   = rnd_q;
		cur_d   = cur_q;
		sqr_d   = sqr_q;
		peq_d   = peq_q;
		arrow_d = arrow_q;
		semi_d  = semi_q;
		drain_d = drain_q;
		stray   = 1'b0;
		fin     = 1'b0;
		clear   = 1'b0;
		produce = 1'b0;
		result.ok     = 1'b0;
		result.code   = ERR_NONE;
		result.line   = '0;
		result.column = '0;
		if (drain_q) begin
			clear = last;
		end else if (empty_source) begin
			fin = last;
		end else if (character == CH_NEWLINE) begin
			line_d = sat_inc(line_q);
			col_d  = ONE;
			peq_d  = 1'b0;
			fin    = last;
		end else begin
			col_d = sat_inc(col_q);
			unique case (character)
				CH_LPAREN:  rnd_d = sat_inc(rnd_q);
				CH_RPAREN: begin
					if (rnd_q == '0) stray = 1'b1;
					else rnd_d = rnd_q - ONE;
				end
				CH_LCURLY:  cur_d = sat_inc(cur_q);
				CH_RCURLY: begin
					if (cur_q == '0) stray = 1'b1;
					else cur_d = cur_q - ONE;
				end
				CH_LSQUARE: sqr_d = sat_inc(sqr_q);
				CH_RSQUARE: begin
					if (sqr_q == '0) stray = 1'b1;
					else sqr_d = sqr_q - ONE;
				end
				CH_SEMI:    semi_d = 1'b1;
				CH_GREATER: begin
					if (peq_q) arrow_d = 1'b1;
				end
				default: ;
			endcase
			peq_d = (character == CH_EQUALS);
			if (stray) begin
				produce       = 1'b1;
				result.code   = ERR_STRAY;
				result.line   = pos16(line_d);
				result.column = pos16(col_d);
				clear         = last;
				drain_d       = !last;
			end else begin
				fin = last;
			end
		end
		if (fin) begin
			produce = 1'b1;
			clear   = 1'b1;
			priority if (rnd_d != '0) begin
				result.code   = ERR_ROUND;
				result.line   = pos16(line_d);
				result.column = pos16(col_d);
			end else if (cur_d != '0) begin
				result.code   = ERR_CURLY;
				result.line   = pos16(line_d);
				result.column = pos16(col_d);
			end else if (sqr_d != '0) begin
				result.code   = ERR_SQUARE;
				result.line   = pos16(line_d);
				result.column = pos16(col_d);
			end else if (!arrow_d && !semi_d) begin
				result.code   = ERR_NO_TERM;
				result.line   = 16'd1;
				result.column = 16'd1;
			end else begin
				result.ok = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= ONE;
			col_q   <= ONE;
			rnd_q   <= '0;
			cur_q   <= '0;
			sqr_q   <= '0;
			peq_q   <= 1'b0;
			arrow_q <= 1'b0;
			semi_q  <= 1'b0;
			drain_q <= 1'b0;
		end else if (step) begin
			if (clear) begin
				line_q  <= ONE;
				col_q   <= ONE;
				rnd_q   <= '0;
				cur_q   <= '0;
				sqr_q   <= '0;
				peq_q   <= 1'b0;
				arrow_q <= 1'b0;
				semi_q  <= 1'b0;
				drain_q <= 1'b0;
			end else begin
				line_q  <= line_d;
				col_q   <= col_d;
				rnd_q   <= rnd_d;
				cur_q   <= cur_d;
				sqr_q   <= sqr_d;
				peq_q   <= peq_d;
				arrow_q <= arrow_d;
				semi_q  <= semi_d;
				drain_q <= drain_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_stray_drains: assert property (@(posedge clk) disable iff (!arst_n)
		step && produce && result.code == ERR_STRAY && !last |=> drain_q)
		else $error("stray closer did not start drain");
	a_drain_silent: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> !produce)
		else $error("result produced while draining");
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> line_q == ONE && col_q == ONE && !drain_q && rnd_q == '0)
		else $error("state not restarted after last transfer");
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		produce |-> (result.ok == (result.code == ERR_NONE)))
		else $error("ok flag disagrees with error code");
`endif

endmodule

### rtl/bbc_out_reg.sv
module bbc_out_reg
	import bbc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result_d,
	output logic    slot_free,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result_q
);

	logic valid_q;

	assign slot_free    = !valid_q || result_ready;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> slot_free)
		else $error("pending result overwritten");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q && result_q == $past(result_d))
		else $error("loaded result not presented");
	a_drop_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_ready && !load |=> !valid_q)
		else $error("taken result still presented");
`endif

endmodule

### rtl/bracket_balance_checker_top.sv
// Bracket balance checker: takes one source byte per transfer (with last and empty_source
// marks) and returns at most one verdict per source: a stray closer at its position,
// a missing ')', '}' or ']' at the final position, neither arrow nor ';' at line 1 column 1,
// or ok. One item is taken every cycle while the input register can advance; a byte is held
// in an input register, passes the scan logic, and any verdict it causes is loaded into the
// output register when that byte advances. Throughput drops only while a finished verdict waits
// on result_ready and the next byte also produces one. No clearing pass after reset.
module bracket_balance_checker_top
	import bbc_pkg::*;
#(
	parameter int COUNTER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  character,
	input  logic        last,
	input  logic        empty_source,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        ok,
	output logic [2:0]  error_code,
	output logic [15:0] line_number,
	output logic [15:0] column_number
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1, empty_s1;
	logic       produce, slot_free, advance, accept;
	result_t    scan_result, out_result;

	assign advance    = valid_s1 && (!produce || slot_free);
	assign item_ready = !valid_s1 || advance;
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1  <= character;
			last_s1  <= last;
			empty_s1 <= empty_source;
		end
	end

	bbc_scan #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.character    (char_s1),
		.last         (last_s1),
		.empty_source (empty_s1),
		.produce      (produce),
		.result       (scan_result)
	);

	bbc_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && produce),
		.result_d     (scan_result),
		.slot_free    (slot_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_q     (out_result)
	);

	assign ok            = out_result.ok;
	assign error_code    = out_result.code;
	assign line_number   = out_result.line;
	assign column_number = out_result.column;

endmodule

### tb/sv/bracket_balance_checker_top_tb.sv
`timescale 1ns / 1ps

module bracket_balance_checker_top_tb;
	import bbc_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		logic       empty;
	} text_item_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [7:0]  character;
	logic        last;
	logic        empty_source;
	logic        result_valid;
	logic        result_ready;
	logic        ok;
	logic [2:0]  error_code;
	logic [15:0] line_number;
	logic [15:0] column_number;

	text_item_t pending_bytes[$];
	result_t    verdicts_due[$];
	int         sender_idle_pct;
	int         receiver_idle_pct;
	int         fail_count;
	bit         byte_taken;

	logic [15:0] line_pos;
	logic [15:0] col_pos;
	logic [15:0] paren_depth;
	logic [15:0] brace_depth;
	logic [15:0] bracket_depth;
	logic        after_equals;
	logic        arrow_found;
	logic        semi_found;
	logic        skipping_to_end;

	bracket_balance_checker_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.character    (character),
		.last         (last),
		.empty_source (empty_source),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.ok           (ok),
		.error_code   (error_code),
		.line_number  (line_number),
		.column_number(column_number)
	);

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic void clear_scan();
		line_pos = 16'd1;
		col_pos = 16'd1;
		paren_depth = 16'd0;
		brace_depth = 16'd0;
		bracket_depth = 16'd0;
		after_equals = 1'b0;
		arrow_found = 1'b0;
		semi_found = 1'b0;
		skipping_to_end = 1'b0;
	endfunction

	function automatic bit end_of_source(output result_t verdict);
		verdict = '0;
		verdict.line = line_pos;
		verdict.column = col_pos;
		if (paren_depth != 16'd0)
			verdict.code = ERR_ROUND;
		else if (brace_depth != 16'd0)
			verdict.code = ERR_CURLY;
		else if (bracket_depth != 16'd0)
			verdict.code = ERR_SQUARE;
		else if (!arrow_found && !semi_found) begin
			verdict.code = ERR_NO_TERM;
			verdict.line = 16'd1;
			verdict.column = 16'd1;
		end else begin
			verdict.ok = 1'b1;
			verdict.code = ERR_NONE;
			verdict.line = 16'd0;
			verdict.column = 16'd0;
		end
		clear_scan();
		return 1'b1;
	endfunction

	function automatic bit predict_verdict(input logic [7:0] ch, input logic fin,
			input logic blank, output result_t verdict);
		bit stray;
		stray = 1'b0;
		verdict = '0;
		if (skipping_to_end) begin
			if (fin)
				clear_scan();
			return 1'b0;
		end
		if (blank) begin
			if (fin)
				return end_of_source(verdict);
			return 1'b0;
		end
		if (ch == CH_NEWLINE) begin
			line_pos = bump(line_pos);
			col_pos = 16'd1;
			after_equals = 1'b0;
			if (fin)
				return end_of_source(verdict);
			return 1'b0;
		end
		col_pos = bump(col_pos);
		case (ch)
			CH_LPAREN:  paren_depth = bump(paren_depth);
			CH_RPAREN: begin
				if (paren_depth == 16'd0)
					stray = 1'b1;
				else
					paren_depth = paren_depth - 16'd1;
			end
			CH_LCURLY:  brace_depth = bump(brace_depth);
			CH_RCURLY: begin
				if (brace_depth == 16'd0)
					stray = 1'b1;
				else
					brace_depth = brace_depth - 16'd1;
			end
			CH_LSQUARE: bracket_depth = bump(bracket_depth);
			CH_RSQUARE: begin
				if (bracket_depth == 16'd0)
					stray = 1'b1;
				else
					bracket_depth = bracket_depth - 16'd1;
			end
			CH_SEMI:    semi_found = 1'b1;
			CH_GREATER: begin
				if (after_equals)
					arrow_found = 1'b1;
			end
			default: ;
		endcase
		after_equals = (ch == CH_EQUALS);
		if (stray) begin
			verdict.ok = 1'b0;
			verdict.code = ERR_STRAY;
			verdict.line = line_pos;
			verdict.column = col_pos;
			if (fin)
				clear_scan();
			else
				skipping_to_end = 1'b1;
			return 1'b1;
		end
		if (fin)
			return end_of_source(verdict);
		return 1'b0;
	endfunction

	function automatic logic [7:0] closer_for(input logic [7:0] opener);
		return (opener == CH_LPAREN) ? CH_RPAREN :
		       (opener == CH_LCURLY) ? CH_RCURLY : CH_RSQUARE;
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] specials[10];
		specials = '{CH_LPAREN, CH_RPAREN, CH_LCURLY, CH_RCURLY, CH_LSQUARE,
			CH_RSQUARE, CH_NEWLINE, CH_EQUALS, CH_GREATER, CH_SEMI};
		if ($urandom_range(3) == 0)
			return 8'($urandom);
		return specials[$urandom_range(9)];
	endfunction

	task automatic add_byte(input logic [7:0] ch, input logic fin, input logic blank);
		text_item_t it;
		it.ch = ch;
		it.last = fin;
		it.empty = blank;
		pending_bytes.push_back(it);
	endtask

	task automatic add_source(input bit well_formed);
		logic [7:0] openers[$];
		logic [7:0] ch;
		int len;
		int i;
		if ($urandom_range(15) == 0) begin
			add_byte(8'($urandom), 1'b1, 1'b1);
			return;
		end
		len = $urandom_range(12, 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				add_byte(8'($urandom), 1'b0, 1'b1);
			if (!well_formed)
				ch = noise_byte();
			else begin
				case ($urandom_range(9))
					0, 1, 2: begin
						case ($urandom_range(2))
							0:       ch = CH_LPAREN;
							1:       ch = CH_LCURLY;
							default: ch = CH_LSQUARE;
						endcase
						openers.push_back(ch);
					end
					3, 4: begin
						if (openers.size() == 0)
							ch = CH_SEMI;
						else
							ch = closer_for(openers.pop_back());
					end
					5:       ch = CH_EQUALS;
					6:       ch = CH_GREATER;
					7:       ch = CH_SEMI;
					8:       ch = CH_NEWLINE;
					default: ch = 8'($urandom);
				endcase
			end
			add_byte(ch, 1'b0, 1'b0);
		end
		if (well_formed) begin
			case ($urandom_range(4))
				0: ;
				1, 2: add_byte(CH_SEMI, 1'b0, 1'b0);
				default: begin
					add_byte(CH_EQUALS, 1'b0, 1'b0);
					add_byte(CH_GREATER, 1'b0, 1'b0);
				end
			endcase
			while (openers.size() > 0)
				add_byte(closer_for(openers.pop_back()), 1'b0, 1'b0);
		end
		if ($urandom_range(4) == 0)
			add_byte(8'($urandom), 1'b1, 1'b1);
		else
			pending_bytes[pending_bytes.size() - 1].last = 1'b1;
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || item_valid || verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	always @(negedge clk) begin
		text_item_t nxt;
		if (arst_n) begin
			result_ready <= ($urandom_range(99) >= receiver_idle_pct);
			if (!item_valid || byte_taken) begin
				if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					nxt = pending_bytes.pop_front();
					item_valid <= 1'b1;
					character <= nxt.ch;
					last <= nxt.last;
					empty_source <= nxt.empty;
				end else
					item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		byte_taken <= item_valid && item_ready;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				if (predict_verdict(character, last, empty_source, want))
					verdicts_due.push_back(want);
			end
			if (result_valid && result_ready) begin
				if (verdicts_due.size() == 0) begin
					$error("result transfer with no verdict pending");
					fail_count++;
				end else begin
					want = verdicts_due.pop_front();
					if (ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, ok);
						fail_count++;
					end
					if (error_code !== want.code) begin
						$error("error_code: expected %0d, got %0d", want.code, error_code);
						fail_count++;
					end
					if (line_number !== want.line) begin
						$error("line_number: expected %0d, got %0d", want.line, line_number);
						fail_count++;
					end
					if (column_number !== want.column) begin
						$error("column_number: expected %0d, got %0d", want.column,
							column_number);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		character = 8'h00;
		last = 1'b0;
		empty_source = 1'b0;
		result_ready = 1'b0;
		fail_count = 0;
		sender_idle_pct = 15;
		receiver_idle_pct = 76;
		clear_scan();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_byte(8'hFF, 1'b1, 1'b1);
		add_byte(CH_LPAREN, 1'b0, 1'b0);
		add_byte(CH_EQUALS, 1'b0, 1'b0);
		add_byte(CH_GREATER, 1'b1, 1'b0);
		add_byte(CH_LCURLY, 1'b0, 1'b0);
		add_byte(CH_SEMI, 1'b1, 1'b0);
		add_byte(CH_LSQUARE, 1'b0, 1'b0);
		add_byte(CH_SEMI, 1'b1, 1'b0);
		add_byte(CH_RPAREN, 1'b1, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(CH_RCURLY, 1'b0, 1'b0);
		add_byte(CH_LPAREN, 1'b0, 1'b0);
		add_byte(CH_RSQUARE, 1'b1, 1'b0);
		add_byte(CH_EQUALS, 1'b0, 1'b0);
		add_byte(CH_NEWLINE, 1'b0, 1'b0);
		add_byte(CH_GREATER, 1'b1, 1'b0);
		add_byte(CH_EQUALS, 1'b0, 1'b0);
		add_byte(8'hA5, 1'b0, 1'b1);
		add_byte(CH_GREATER, 1'b1, 1'b0);
		add_byte(CH_LSQUARE, 1'b0, 1'b0);
		add_byte(CH_NEWLINE, 1'b0, 1'b0);
		add_byte(CH_RSQUARE, 1'b0, 1'b0);
		add_byte(8'hFF, 1'b0, 1'b0);
		add_byte(CH_SEMI, 1'b0, 1'b0);
		add_byte(CH_NEWLINE, 1'b1, 1'b0);
		while (pending_bytes.size() < 300)
			add_source($urandom_range(3) != 0);
		wait_drained();

		sender_idle_pct = 76;
		receiver_idle_pct = 15;
		while (pending_bytes.size() < 300)
			add_source($urandom_range(3) != 0);
		wait_drained();

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		while (pending_bytes.size() < 300)
			add_source($urandom_range(3) != 0);
		wait_drained();

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
